@@ design/float_to_fixed_quantizer_macros.svh @@
// assertion macros for the float to fixed quantizer
`ifndef FLOAT_TO_FIXED_QUANTIZER_MACROS_SVH
`define FLOAT_TO_FIXED_QUANTIZER_MACROS_SVH
`ifndef SYNTHESIS
`define FFQ_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define FFQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define FFQ_ASSERT_IMPL(label, clk, rst_n, prop)
`define FFQ_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ design/ffq_pkg.sv @@
// ----------------------------------------------------------------------------
// ffq_pkg
// shared types and constants of the float to fixed quantizer
// ----------------------------------------------------------------------------
package ffq_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 6;

    localparam logic [CfgIdxW-1:0] REG_INT_BITS   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_FRAC_BITS  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_ROUND_MODE = 2'd2;

    typedef struct packed {
        logic [5:0] int_bits;
        logic [4:0] frac_bits;
        logic       round_mode;
    } ffq_cfg_t;

    typedef struct packed {
        logic [31:0] quantized;
        logic        clipped;
        logic        last_out;
    } ffq_result_t;

endpackage

@@ design/ffq_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ffq_cfg_regs
// configuration register file written through a plain write port
// ----------------------------------------------------------------------------
module ffq_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ffq_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [ffq_pkg::CfgDataW-1:0] cfg_data,
    output ffq_pkg::ffq_cfg_t            cfg
);
    import ffq_pkg::*;

    ffq_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.int_bits   <= 6'd8;
            cfg_reg.frac_bits  <= 5'd8;
            cfg_reg.round_mode <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INT_BITS:   cfg_reg.int_bits   <= cfg_data;
                REG_FRAC_BITS:  cfg_reg.frac_bits  <= cfg_data[4:0];
                REG_ROUND_MODE: cfg_reg.round_mode <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

@@ design/ffq_convert.sv @@
// ----------------------------------------------------------------------------
// ffq_convert
// combinational scale, round and saturate of one single-precision value
// ----------------------------------------------------------------------------
module ffq_convert (
    input  ffq_pkg::ffq_cfg_t    cfg,
    input  logic [31:0]          value_bits,
    input  logic                 last_in,
    output ffq_pkg::ffq_result_t res
);
    import ffq_pkg::*;

    logic        neg;
    logic [7:0]  ex;
    logic [23:0] man;
    logic [9:0]  s;           // signed shift, e - 150 + frac_bits
    logic [5:0]  k;
    logic [40:0] mag;
    logic [63:0] shl;
    logic [23:0] q;
    logic [23:0] rem_mask;
    logic [24:0] hsh;
    logic        half;
    logic        rem_nz;
    logic [6:0]  w;
    logic [41:0] sv;
    logic [41:0] maxv;
    logic [41:0] minv;

    always_comb
    begin
        neg = value_bits[31];
        ex  = value_bits[30:23];
        man = {(ex != 8'd0), value_bits[22:0]};
        s   = 10'((ex == 8'd0) ? 10'd1 : {2'b00, ex}) - 10'd150
              + {5'd0, cfg.frac_bits};
        k   = 6'd0;
        shl = 64'd0;
        q   = 24'd0;
        rem_mask = 24'd0;
        hsh = 25'd0;
        half = 1'b0;
        rem_nz = 1'b0;
        if (ex == 8'hFF)
            mag = 41'h100_0000_0000;
        else if (man == 24'd0)
            mag = 41'd0;
        else if (!s[9])
        begin
            if (s > 10'd39)
                mag = 41'h100_0000_0000;
            else
            begin
                shl = {40'd0, man} << s[5:0];
                mag = (shl > 64'h100_0000_0000) ? 41'h100_0000_0000 : shl[40:0];
            end
        end
        else
        begin
            // right shift; anything beyond 25 places leaves nothing in q or half
            k = ((10'd0 - s) > 10'd25) ? 6'd25 : 6'(10'd0 - s);
            q = man >> k;
            rem_mask = ~(24'hFF_FFFF << k);
            rem_nz = (man & rem_mask) != 24'd0;
            // bit just below the kept part
            hsh = {man, 1'b0} >> k;
            half = hsh[0];
            if (cfg.round_mode)
                mag = {17'd0, q} + {40'd0, half};
            else
                mag = {17'd0, q} + {40'd0, neg && rem_nz};
        end

        w = {1'b0, cfg.int_bits} + {2'b00, cfg.frac_bits};
        if (w > 7'd32)
            w = 7'd32;
        if (w < 7'd1)
            w = 7'd1;
        maxv = (42'd1 << (w - 7'd1)) - 42'd1;
        minv = 42'd0 - (42'd1 << (w - 7'd1));
        sv = neg ? (42'd0 - {1'b0, mag}) : {1'b0, mag};

        res.last_out = last_in;
        res.clipped  = 1'b0;
        res.quantized = sv[31:0];
        if (ex == 8'hFF && value_bits[22:0] != 23'd0)
            res.quantized = 32'd0;
        else if ($signed(sv) > $signed(maxv))
        begin
            res.quantized = maxv[31:0];
            res.clipped   = 1'b1;
        end
        else if ($signed(sv) < $signed(minv))
        begin
            res.quantized = minv[31:0];
            res.clipped   = 1'b1;
        end
    end
endmodule

@@ design/float_to_fixed_quantizer.sv @@
// ----------------------------------------------------------------------------
// float_to_fixed_quantizer
// single-precision to saturated signed fixed point; while the output is not stalled, one request per cycle
// ----------------------------------------------------------------------------
// the accepted request is held in the input register and its converted result in the result register
// throughput: one request per cycle while the output is not stalled
// the input stalls only while both registers hold requests and the output is stalled
// reset: asynchronous, clears valids and loads int 8, frac 8, round to nearest
module float_to_fixed_quantizer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ffq_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [ffq_pkg::CfgDataW-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [31:0]                  value_bits,
    input  logic                         last_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [31:0]           quantized,
    output logic                         clipped,
    output logic                         last_out
);
    import ffq_pkg::*;

`include "float_to_fixed_quantizer_macros.svh"

    ffq_cfg_t    cfg;
    ffq_result_t res;
    logic        a_valid_reg;
    logic [31:0] a_value_reg;
    logic        a_last_reg;
    logic        r_valid_reg;
    ffq_result_t r_data_reg;
    logic        r_load;
    logic        a_load;

    ffq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ffq_convert u_conv (
        .cfg        (cfg),
        .value_bits (a_value_reg),
        .last_in    (a_last_reg),
        .res        (res)
    );

    assign r_load   = a_valid_reg && (!r_valid_reg || !out_stall);
    assign in_stall = a_valid_reg && !r_load;
    assign a_load   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_load || r_load)
                a_valid_reg <= a_load;
            if (r_load)
                r_valid_reg <= 1'b1;
            else if (!out_stall)
                r_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_value_reg <= value_bits;
            a_last_reg  <= last_in;
        end
        if (r_load)
            r_data_reg <= res;
    end

    assign out_valid = r_valid_reg;
    assign quantized = r_data_reg.quantized;
    assign clipped   = r_data_reg.clipped;
    assign last_out  = r_data_reg.last_out;

    `FFQ_ASSERT_NEXT(a_stage_keeps, clk, rst_n, in_stall, a_valid_reg)
    `FFQ_ASSERT_NEXT(r_fills, clk, rst_n, r_load, out_valid)
    `FFQ_ASSERT_IMPL(stall_only_full, clk, rst_n, in_stall |-> (r_valid_reg && out_stall))
endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// float to fixed quantizer testbench: a directed table followed by random
// floats under several idling phases, checked in order against a predictor
// ----------------------------------------------------------------------------
module tb;
    import ffq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] value_bits;
        logic        last_in;
        logic        typed;
        logic [31:0] quantized;
        logic        clipped;
    } vec_t;

    typedef struct {
        logic [31:0] quantized;
        logic        clipped;
        logic        last_out;
    } quant_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [31:0]         value_bits;
    logic                last_in;
    logic                out_valid;
    logic                out_stall;
    logic signed [31:0]  quantized;
    logic                clipped;
    logic                last_out;

    float_to_fixed_quantizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_bits (value_bits),
        .last_in    (last_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .quantized  (quantized),
        .clipped    (clipped),
        .last_out   (last_out)
    );

    logic [5:0] int_bits_q;
    logic [4:0] frac_bits_q;
    logic       round_q;

    quant_t      quant_queue[$];
    int unsigned mismatch_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_recv;
    int unsigned hold_cycles;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic quant_t quantize(logic [31:0] bits, logic last);
        quant_t      r;
        logic        neg;
        logic [7:0]  ex;
        logic [63:0] m;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        longint      v;
        longint      maxv;
        longint      minv;
        int          w;
        int          s;
        int          k;
        neg = bits[31];
        ex = bits[30:23];
        m = {41'd0, bits[22:0]};
        r.last_out = last;
        r.clipped = 1'b0;
        w = int_bits_q + frac_bits_q;
        if (w > 32)
            w = 32;
        if (w < 1)
            w = 1;
        maxv = (64'sd1 <<< (w - 1)) - 1;
        minv = -(64'sd1 <<< (w - 1));
        if (ex == 8'hff && m != 0)
        begin
            r.quantized = 32'd0;
            return r;
        end
        if (ex == 8'hff)
            mag = 64'd1 << 40;
        else
        begin
            if (ex != 0)
                m[23] = 1'b1;
            s = ((ex == 0) ? 1 : int'(ex)) - 150 + int'(frac_bits_q);
            if (m == 0)
                mag = 0;
            else if (s >= 0)
            begin
                if (s > 39)
                    mag = 64'd1 << 40;
                else
                begin
                    mag = m << s;
                    if (mag > (64'd1 << 40))
                        mag = 64'd1 << 40;
                end
            end
            else
            begin
                k = -s;
                if (k >= 64)
                begin
                    q = 0;
                    rem = m;
                    half = 0;
                end
                else
                begin
                    q = m >> k;
                    rem = m & ((64'd1 << k) - 1);
                    half = (m >> (k - 1)) & 64'd1;
                end
                if (round_q)
                    mag = q + half;
                else
                    mag = q + ((neg && rem != 0) ? 64'd1 : 64'd0);
            end
        end
        v = neg ? -longint'(mag) : longint'(mag);
        if (v > maxv)
        begin
            v = maxv;
            r.clipped = 1'b1;
        end
        else if (v < minv)
        begin
            v = minv;
            r.clipped = 1'b1;
        end
        r.quantized = v[31:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        quant_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (quant_queue.size() == 0)
                report("unexpected result", quantized, 32'd0);
            else
            begin
                e = quant_queue.pop_front();
                if (quantized !== e.quantized)
                    report("quantized", quantized, e.quantized);
                if (clipped !== e.clipped)
                    report("clipped", {31'd0, clipped}, {31'd0, e.clipped});
                if (last_out !== e.last_out)
                    report("last_out", {31'd0, last_out}, {31'd0, e.last_out});
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= hold_recv || ($urandom_range(99, 0) < recv_stall_pct);
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [5:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        case (idx)
            REG_INT_BITS:   int_bits_q = data;
            REG_FRAC_BITS:  frac_bits_q = data[4:0];
            REG_ROUND_MODE: round_q = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_format(int ib, int fb, int rm);
        write_reg(REG_INT_BITS, 6'(ib));
        write_reg(REG_FRAC_BITS, 6'(fb));
        write_reg(REG_ROUND_MODE, 6'(rm));
    endtask

    // called at a falling edge; returns at a falling edge once accepted
    task automatic send(logic [31:0] bits, logic last);
        while ($urandom_range(99, 0) < send_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        value_bits = bits;
        last_in = last;
        quant_queue.push_back(quantize(bits, last));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        value_bits = $urandom;
    endtask

    task automatic drain();
        while (quant_queue.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    function automatic logic [31:0] random_float();
        logic [31:0] f;
        int unsigned pick;
        f = $urandom;
        pick = $urandom_range(9, 0);
        // keep most exponents near the interesting scale region
        if (pick < 6)
            f[30:23] = 8'($urandom_range(160, 100));
        else if (pick == 6)
            f[30:23] = 8'($urandom_range(3, 0));
        else if (pick == 7)
            f[30:23] = 8'hff;
        else if (pick == 8)
            f[22:0] = {2'($urandom_range(3, 0)), 21'd0};
        return f;
    endfunction

    vec_t table_q[$];

    initial
    begin
        #200000000;
        $display("float_to_fixed_quantizer verification failed");
        $finish;
    end

    initial
    begin
        int unsigned ph;
        vec_t row;
        quant_t e;
        int unsigned f;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_INT_BITS;
        cfg_data = '0;
        in_valid = 1'b0;
        value_bits = '0;
        last_in = 1'b0;
        out_stall = 1'b0;
        hold_recv = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        int_bits_q = 6'd8;
        frac_bits_q = 5'd8;
        round_q = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // after reset: Q8.8, nearest rounding, range -32768..32767
        table_q = '{
            '{32'h3f800000, 1'b0, 1'b1, 32'd256, 1'b0},
            '{32'hbf800000, 1'b1, 1'b1, -32'sd256, 1'b0},
            '{32'h00000000, 1'b0, 1'b1, 32'd0, 1'b0},
            '{32'h80000000, 1'b0, 1'b1, 32'd0, 1'b0},
            '{32'h7fc00000, 1'b1, 1'b1, 32'd0, 1'b0},
            '{32'hffffffff, 1'b0, 1'b1, 32'd0, 1'b0},
            '{32'h7f800000, 1'b0, 1'b1, 32'd32767, 1'b1},
            '{32'hff800000, 1'b1, 1'b1, -32'sd32768, 1'b1},
            '{32'h7f7fffff, 1'b0, 1'b1, 32'd32767, 1'b1},
            '{32'hff7fffff, 1'b0, 1'b1, -32'sd32768, 1'b1},
            '{32'h00000001, 1'b0, 1'b0, 0, 0},
            '{32'h807fffff, 1'b0, 1'b0, 0, 0},
            '{32'h3b000000, 1'b0, 1'b0, 0, 0},
            '{32'hbb000000, 1'b0, 1'b0, 0, 0},
            '{32'h3bc00000, 1'b1, 1'b0, 0, 0},
            '{32'h46fffe00, 1'b0, 1'b0, 0, 0},
            '{32'hc7000000, 1'b0, 1'b0, 0, 0},
            '{32'h40490fdb, 1'b0, 1'b0, 0, 0}
        };
        foreach (table_q[i])
        begin
            row = table_q[i];
            send(row.value_bits, row.last_in);
            if (row.typed)
            begin
                e = quant_queue[quant_queue.size() - 1];
                if (e.quantized !== row.quantized || e.clipped !== row.clipped)
                    report("table row", e.quantized, row.quantized);
            end
        end
        drain();

        // floor rounding and the extreme formats
        set_format(8, 8, 0);
        foreach (table_q[i])
            send(table_q[i].value_bits, table_q[i].last_in);
        drain();
        set_format(0, 0, 1);
        foreach (table_q[i])
            send(table_q[i].value_bits, table_q[i].last_in);
        drain();
        set_format(63, 31, 0);
        foreach (table_q[i])
            send(table_q[i].value_bits, table_q[i].last_in);
        drain();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            case (ph)
                0: set_format(1, 0, 0);
                1: set_format(32, 31, 1);
                2: set_format(16, 16, 1);
                3: set_format(4, 12, 0);
                4: set_format(1, 31, 1);
                5: set_format(24, 0, 0);
                6: set_format($urandom_range(63, 0), $urandom_range(31, 0), 1);
                default: set_format($urandom_range(63, 0), $urandom_range(31, 0), 0);
            endcase
            if (ph == 2)
            begin
                // long receiver hold-off while requests keep coming
                @(negedge clk);
                hold_cycles = 60;
            end
            for (f = 0; f < 160; f++)
                send(random_float(), 1'($urandom_range(1, 0)));
            // sender waits for every expected result
            drain();
        end

        drain();
        if (mismatch_count == 0)
            $display("float_to_fixed_quantizer verification clean");
        else
            $display("float_to_fixed_quantizer verification failed");
        $finish;
    end
endmodule
